// ----- hdl/twcs_pkg.sv -----
// Shared types, codes and constants of the textured wall column shader.
package twcs_pkg;

	localparam int TEX_DIM_MAX_DEF = 64;
	localparam int WALL_SIDES_DEF  = 4;
	localparam int ROWS_MAX        = 1024;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WALL_SCALE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_W       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_H       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLUMNS = 3'd5;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_COLUMN = 2'd1;
	localparam logic [1:0] KIND_PIXEL  = 2'd2;

	localparam logic RES_SPAN  = 1'b0;
	localparam logic RES_PIXEL = 1'b1;

	localparam logic [15:0] SHADE_FLOOR = 16'd6554;
	localparam logic [15:0] SHADE_MAX   = 16'hFFFF;

	localparam int DIV_NW = 33;
	localparam int DIV_DW = 24;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  texture_side;
		logic [5:0]  load_column;
		logic [5:0]  load_row;
		logic [23:0] texel_color;
		logic [23:0] ray_distance;
		logic [15:0] hit_fraction;
		logic        hit_axis;
		logic        step_x_positive;
		logic        step_y_negative;
		logic [9:0]  screen_column;
		logic [9:0]  screen_row;
	} in_word_t;

	typedef struct packed {
		logic        result_kind;
		logic [9:0]  out_column;
		logic [9:0]  out_row;
		logic [9:0]  span_start;
		logic [9:0]  span_end;
		logic [5:0]  texture_column;
		logic [23:0] pixel_color;
		logic        inside_wall;
	} out_word_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- hdl/twcs_stream_if.sv -----
// Valid/ready word channel.
interface twcs_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- hdl/twcs_ram.sv -----
// Generic single-port RAM with registered read.
module twcs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- hdl/twcs_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module twcs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [twcs_pkg::DIV_NW-1:0] num,
	input  logic [twcs_pkg::DIV_DW-1:0] den,
	output logic [twcs_pkg::DIV_NW-1:0] quot,
	output twcs_pkg::div_stat_t         stat
);
	import twcs_pkg::*;

	localparam int CW = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic              take;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign take  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= num;
				den_q  <= den;
				cnt_q  <= CW'(DIV_NW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= take ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
				quo_q <= {quo_q[DIV_NW-2:0], take};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot      = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

// ----- hdl/textured_wall_column_shader.sv -----
// Top level: raycaster wall column texturer and distance shader.
//
//  channel | dir | handshake         | word
//  cmd     | in  | valid/ready       | in_word_t (load, column, pixel)
//  res     | out | valid/ready       | out_word_t (span or pixel)
//  cfg     | in  | cfg_we, no ready  | cfg_index, cfg_data
//
// Texel load: written on acceptance if in range. Column: two passes through
// the 33-step divider (half height, then shade). Pixel inside the span: one
// divider pass plus texture RAM read; zero-height span: RAM read only;
// outside the span: neither. A result waiting in the output register stalls
// the emit. One word is processed at a time; the output register frees the
// input side while a result waits. No clearing pass after reset.
module textured_wall_column_shader #(
	parameter int TEX_DIM_MAX = twcs_pkg::TEX_DIM_MAX_DEF,
	parameter int WALL_SIDES  = twcs_pkg::WALL_SIDES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [twcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [twcs_pkg::CFG_DATA_W-1:0] cfg_data,
	twcs_stream_if.sink                     cmd,
	twcs_stream_if.source                   res
);
	import twcs_pkg::*;

	localparam int TCW   = $clog2(TEX_DIM_MAX);
	localparam int DEPTH = WALL_SIDES * TEX_DIM_MAX * TEX_DIM_MAX;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE, ST_HH, ST_HH_W, ST_SH, ST_SH_W,
		ST_PIX_DIV, ST_PIX_W, ST_PIX_RA, ST_PIX_RD, ST_EMIT
	} state_t;

	state_t state_q;

	logic [7:0]  tile_q;
	logic [9:0]  scale_q;
	logic [10:0] sh_q;
	logic [6:0]  texw_q;
	logic [6:0]  texh_q;
	logic [7:0]  mapc_q;

	logic [7:0]  ts, mc;
	logic [10:0] h;
	logic [6:0]  tw, th;

	logic [10:0]    cur_start_q, cur_end_q;
	logic [TCW-1:0] cur_tx_q;
	logic [15:0]    cur_shade_q;
	logic [1:0]     cur_side_q;
	logic [9:0]     cur_col_q;

	logic [23:0] d_q;
	logic [17:0] prod1_q;
	logic [15:0] prod2_q;
	logic [22:0] tx_prod_q;
	logic        mir_q;
	logic [1:0]  side_l_q;
	logic [9:0]  col_l_q;
	logic        is_pix_q;
	logic [9:0]  y_q;
	logic        inside_q;
	logic [23:0] color_q;
	logic [10:0] span_q;
	logic [17:0] prody_q;
	logic [6:0]  ty_q;

	out_word_t res_q;
	logic      out_valid_q;

	in_word_t w;
	logic     acc;
	logic     load_ok;

	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic [DIV_NW-1:0] div_q;
	div_stat_t         div_st;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [AW-1:0] load_addr;
	logic [AW-1:0] rd_addr;
	logic [23:0]   ram_rdata;

	logic [17:0] mid;
	logic [33:0] end_sum;
	logic [25:0] end_v;
	logic [16:0] shade_t;
	logic [6:0]  tx_raw;
	logic        y_in;
	logic [10:0] y_off;
	logic [23:0] texel;
	logic [23:0] mul_r, mul_g, mul_b;
	logic        emit_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q  <= 8'd64;
			scale_q <= 10'd64;
			sh_q    <= 11'd600;
			texw_q  <= 7'd64;
			texh_q  <= 7'd64;
			mapc_q  <= 8'd24;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TILE_SIZE:   tile_q  <= cfg_data[7:0];
				CFG_WALL_SCALE:  scale_q <= cfg_data[9:0];
				CFG_SCREEN_H:    sh_q    <= cfg_data[10:0];
				CFG_TEX_W:       texw_q  <= cfg_data[6:0];
				CFG_TEX_H:       texh_q  <= cfg_data[6:0];
				CFG_MAP_COLUMNS: mapc_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ts = (tile_q == 8'd0) ? 8'd1 : tile_q;
		mc = (mapc_q == 8'd0) ? 8'd1 : mapc_q;
		if (sh_q < 11'd2) h = 11'd2;
		else if (int'(sh_q) > ROWS_MAX) h = 11'(ROWS_MAX);
		else h = sh_q;
		if (texw_q == 7'd0) tw = 7'd1;
		else if (int'(texw_q) > TEX_DIM_MAX) tw = 7'(TEX_DIM_MAX);
		else tw = texw_q;
		if (texh_q == 7'd0) th = 7'd1;
		else if (int'(texh_q) > TEX_DIM_MAX) th = 7'(TEX_DIM_MAX);
		else th = texh_q;
	end

	assign w         = cmd.data;
	assign cmd.ready = (state_q == ST_IDLE);
	assign acc       = cmd.valid && cmd.ready;

	assign load_ok = (int'(w.texture_side) < WALL_SIDES) &&
		(int'(w.load_column) < TEX_DIM_MAX) && (int'(w.load_row) < TEX_DIM_MAX);
	assign ram_we    = acc && (w.kind == KIND_LOAD) && load_ok;
	assign load_addr = AW'((int'(w.texture_side) * TEX_DIM_MAX + int'(w.load_row))
		* TEX_DIM_MAX + int'(w.load_column));
	assign rd_addr   = AW'((int'(cur_side_q) * TEX_DIM_MAX + int'(ty_q))
		* TEX_DIM_MAX + int'(cur_tx_q));
	assign ram_addr  = ram_we ? load_addr : rd_addr;

	twcs_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_tex (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(w.texel_color),
		.rdata(ram_rdata)
	);

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_HH: begin
				div_start = 1'b1;
				div_num   = {prod1_q, 15'd0};
				div_den   = d_q;
			end
			ST_SH: begin
				div_start = 1'b1;
				div_num   = {d_q, 9'd0};
				div_den   = DIV_DW'(prod2_q);
			end
			ST_PIX_DIV: begin
				div_start = 1'b1;
				div_num   = DIV_NW'(prody_q);
				div_den   = DIV_DW'(span_q);
			end
			default: ;
		endcase
	end

	twcs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quot  (div_q),
		.stat  (div_st)
	);

	always_comb begin
		mid     = {h[10:1], 8'd0};
		end_sum = 34'(div_q) + 34'(mid);
		end_v   = end_sum[33:8];
		shade_t = 17'h10000 - {1'b0, div_q[15:0]};
		tx_raw  = tx_prod_q[22:16];
		y_in    = (11'(w.screen_row) >= cur_start_q) && (11'(w.screen_row) <= cur_end_q);
		y_off   = 11'(w.screen_row) - cur_start_q;
		texel   = (int'(cur_side_q) < WALL_SIDES) ? ram_rdata : 24'd0;
		mul_r   = texel[23:16] * cur_shade_q;
		mul_g   = texel[15:8] * cur_shade_q;
		mul_b   = texel[7:0] * cur_shade_q;
		emit_go = !out_valid_q || res.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			res_q       <= '0;
			cur_start_q <= '0;
			cur_end_q   <= '0;
			cur_tx_q    <= '0;
			cur_shade_q <= '0;
			cur_side_q  <= '0;
			cur_col_q   <= '0;
			d_q         <= '0;
			prod1_q     <= '0;
			prod2_q     <= '0;
			tx_prod_q   <= '0;
			mir_q       <= 1'b0;
			side_l_q    <= '0;
			col_l_q     <= '0;
			is_pix_q    <= 1'b0;
			y_q         <= '0;
			inside_q    <= 1'b0;
			color_q     <= '0;
			span_q      <= '0;
			prody_q     <= '0;
			ty_q        <= '0;
		end else begin
			if (res.ready && !(state_q == ST_EMIT && emit_go)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && w.kind == KIND_COLUMN) begin
						is_pix_q  <= RES_SPAN;
						y_q       <= '0;
						inside_q  <= 1'b0;
						color_q   <= '0;
						d_q       <= (w.ray_distance == 24'd0) ? 24'd256 : w.ray_distance;
						prod1_q   <= scale_q * ts;
						prod2_q   <= mc * ts;
						tx_prod_q <= w.hit_fraction * tw;
						mir_q     <= (!w.hit_axis && w.step_x_positive) ||
							(w.hit_axis && w.step_y_negative);
						side_l_q  <= w.texture_side;
						col_l_q   <= w.screen_column;
						state_q   <= ST_HH;
					end else if (acc && w.kind == KIND_PIXEL) begin
						is_pix_q <= RES_PIXEL;
						y_q      <= w.screen_row;
						inside_q <= y_in;
						color_q  <= '0;
						span_q   <= cur_end_q - cur_start_q;
						prody_q  <= y_off * th;
						ty_q     <= '0;
						if (!y_in) begin
							state_q <= ST_EMIT;
						end else if (cur_end_q == cur_start_q) begin
							state_q <= ST_PIX_RA;
						end else begin
							state_q <= ST_PIX_DIV;
						end
					end
				end
				ST_HH: state_q <= ST_HH_W;
				ST_HH_W: begin
					if (div_st.done) begin
						cur_start_q <= (div_q >= DIV_NW'(mid)) ? 11'd0 :
							11'((mid - div_q[17:0]) >> 8);
						cur_end_q   <= (end_v >= 26'(h)) ? h - 11'd1 : end_v[10:0];
						state_q     <= ST_SH;
					end
				end
				ST_SH: state_q <= ST_SH_W;
				ST_SH_W: begin
					if (div_st.done) begin
						if (div_q == '0) begin
							cur_shade_q <= SHADE_MAX;
						end else if (div_q >= DIV_NW'(17'h10000)) begin
							cur_shade_q <= SHADE_FLOOR;
						end else if (shade_t < 17'(SHADE_FLOOR)) begin
							cur_shade_q <= SHADE_FLOOR;
						end else begin
							cur_shade_q <= shade_t[15:0];
						end
						cur_tx_q   <= mir_q ? TCW'(tw - tx_raw - 7'd1) : TCW'(tx_raw);
						cur_side_q <= side_l_q;
						cur_col_q  <= col_l_q;
						state_q    <= ST_EMIT;
					end
				end
				ST_PIX_DIV: state_q <= ST_PIX_W;
				ST_PIX_W: begin
					if (div_st.done) begin
						ty_q    <= (div_q >= DIV_NW'(th)) ? th - 7'd1 : div_q[6:0];
						state_q <= ST_PIX_RA;
					end
				end
				ST_PIX_RA: state_q <= ST_PIX_RD;
				ST_PIX_RD: begin
					color_q <= {mul_r[23:16], mul_g[23:16], mul_b[23:16]};
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						res_q.result_kind    <= is_pix_q;
						res_q.out_column     <= cur_col_q;
						res_q.out_row        <= y_q;
						res_q.span_start     <= cur_start_q[9:0];
						res_q.span_end       <= cur_end_q[9:0];
						res_q.texture_column <= 6'(cur_tx_q);
						res_q.pixel_color    <= color_q;
						res_q.inside_wall    <= inside_q;
						out_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = res_q;

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_HH_W || state_q == ST_SH_W || state_q == ST_PIX_W))
		else $error("divider finished outside a wait state");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		cur_start_q <= cur_end_q)
		else $error("span start beyond span end");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE && !div_st.busy))
		else $error("texture write while busy");

	a_start_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider restarted while busy");
endmodule

// ----- dv/twcs_checker.sv -----
// Checker: watches command and result channels, predicts results and compares them.
module twcs_checker
	import twcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  in_word_t  cmd_data,
	input  logic      res_valid,
	input  logic      res_ready,
	input  out_word_t res_data,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [23:0] texels [0:4*64*64-1];
	logic [7:0]  r_tile;
	logic [9:0]  r_scale;
	logic [10:0] r_height;
	logic [6:0]  r_tw;
	logic [6:0]  r_th;
	logic [7:0]  r_map;
	logic [9:0]  c_start, c_end, c_col;
	logic [5:0]  c_tx;
	logic [15:0] c_shade;
	logic [1:0]  c_side;
	out_word_t   expected_q [$];

	assign pending = expected_q.size();

	function automatic logic [7:0] shade8(logic [7:0] c, logic [15:0] s);
		logic [23:0] p;
		p = c * s;
		return p[23:16];
	endfunction

	task automatic predict_word(input in_word_t w);
		longint unsigned ts, mc, h, tw, th, d, hh, mid, endv, ratio, shade, tx;
		longint unsigned ty, span;
		logic [23:0] texel;
		out_word_t o;
		ts = (r_tile == 0) ? 1 : r_tile;
		mc = (r_map == 0) ? 1 : r_map;
		h = (r_height < 2) ? 2 : (r_height > ROWS_MAX ? ROWS_MAX : r_height);
		tw = (r_tw < 1) ? 1 : (r_tw > 64 ? 64 : r_tw);
		th = (r_th < 1) ? 1 : (r_th > 64 ? 64 : r_th);
		o = '0;
		case (w.kind)
			KIND_LOAD: begin
				texels[{w.texture_side, w.load_row, w.load_column}] = w.texel_color;
			end
			KIND_COLUMN: begin
				d = (w.ray_distance == 0) ? 256 : w.ray_distance;
				hh = ((r_scale * ts) << 15) / d;
				mid = (h / 2) << 8;
				c_start = (hh >= mid) ? 0 : 10'((mid - hh) >> 8);
				endv = (mid + hh) >> 8;
				c_end = (endv >= h) ? 10'(h - 1) : 10'(endv);
				tx = (w.hit_fraction * tw) >> 16;
				if ((!w.hit_axis && w.step_x_positive) || (w.hit_axis && w.step_y_negative))
					tx = tw - tx - 1;
				c_tx = 6'(tx);
				ratio = (d << 9) / (mc * ts);
				shade = (ratio >= 65536) ? 0 : 65536 - ratio;
				if (shade > 65535) shade = 65535;
				if (shade < SHADE_FLOOR) shade = SHADE_FLOOR;
				c_shade = 16'(shade);
				c_side = w.texture_side;
				c_col = w.screen_column;
				o.result_kind = RES_SPAN;
				o.out_column = c_col;
				o.span_start = c_start;
				o.span_end = c_end;
				o.texture_column = c_tx;
				expected_q.push_back(o);
			end
			KIND_PIXEL: begin
				o.result_kind = RES_PIXEL;
				o.out_column = c_col;
				o.out_row = w.screen_row;
				o.span_start = c_start;
				o.span_end = c_end;
				o.texture_column = c_tx;
				if (w.screen_row >= c_start && w.screen_row <= c_end) begin
					span = c_end - c_start;
					ty = (span != 0) ? ((w.screen_row - c_start) * th) / span : 0;
					if (ty > th - 1) ty = th - 1;
					texel = texels[{c_side, 6'(ty), c_tx}];
					o.pixel_color = {shade8(texel[23:16], c_shade),
						shade8(texel[15:8], c_shade), shade8(texel[7:0], c_shade)};
					o.inside_wall = 1'b1;
				end
				expected_q.push_back(o);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_tile <= 8'd64; r_scale <= 10'd64; r_height <= 11'd600;
			r_tw <= 7'd64; r_th <= 7'd64; r_map <= 8'd24;
			c_start = '0; c_end = '0; c_col = '0; c_tx = '0;
			c_shade = '0; c_side = '0;
			errors <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TILE_SIZE:   r_tile <= cfg_data[7:0];
					CFG_WALL_SCALE:  r_scale <= cfg_data[9:0];
					CFG_SCREEN_H:    r_height <= cfg_data;
					CFG_TEX_W:       r_tw <= cfg_data[6:0];
					CFG_TEX_H:       r_th <= cfg_data[6:0];
					CFG_MAP_COLUMNS: r_map <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (res_valid && res_ready) begin
				if (expected_q.size() == 0) begin
					$display("%t unexpected word %h", $realtime, res_data);
					errors <= errors + 1;
				end else if (expected_q[0] !== res_data) begin
					$display("%t mismatch: expected %p actual %p", $realtime,
						expected_q[0], res_data);
					errors <= errors + 1;
					void'(expected_q.pop_front());
				end else
					void'(expected_q.pop_front());
			end
			if (cmd_valid && cmd_ready)
				predict_word(cmd_data);
		end
	end
endmodule

// ----- dv/tb.sv -----
// Testbench top: drives textured_wall_column_shader with directed and random words.
module tb;
	import twcs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IW = $bits(in_word_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int errors, pending;
	int gap_left = 0;

	twcs_stream_if #(in_word_t)  cmd();
	twcs_stream_if #(out_word_t) res();

	textured_wall_column_shader u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd(cmd.sink), .res(res.source)
	);

	twcs_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
		.cmd_data(cmd.data), .res_valid(res.valid), .res_ready(res.ready),
		.res_data(res.data), .errors(errors), .pending(pending)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		case ($urandom_range(0, 3))
			0: res.ready <= 1'b0;
			1: res.ready <= ($urandom_range(0, 3) == 0);
			default: res.ready <= 1'b1;
		endcase
	end

	task automatic send_word(input in_word_t w);
		if (gap_left == 0 && $urandom_range(0, 7) == 0)
			gap_left = $urandom_range(1, 12);
		while (gap_left > 0) begin
			@(posedge clk);
			cmd.valid <= 1'b0;
			gap_left--;
		end
		@(posedge clk);
		cmd.valid <= 1'b1;
		cmd.data <= w;
		do @(posedge clk); while (!cmd.ready);
		cmd.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_all_texels();
		in_word_t w;
		for (int s = 0; s < 4; s++)
			for (int r = 0; r < 8; r++)
				for (int c = 0; c < 8; c++) begin
					w = '0;
					w.kind = KIND_LOAD;
					w.texture_side = 2'(s);
					w.load_row = 6'(r);
					w.load_column = 6'(c);
					w.texel_color = 24'($urandom);
					if (r == 0 && c == 0) w.texel_color = 24'hFFFFFF;
					send_word(w);
				end
	endtask

	function automatic in_word_t rand_word(input logic [1:0] k);
		in_word_t w;
		w = in_word_t'(IW'({$urandom, $urandom, $urandom, $urandom}));
		w.kind = k;
		case ($urandom_range(0, 3))
			0: w.ray_distance = 24'($urandom_range(0, 1024));
			1: w.ray_distance = 24'($urandom_range(0, 65535));
			default: ;
		endcase
		if ($urandom_range(0, 1)) w.screen_row = 10'($urandom_range(0, 700));
		return w;
	endfunction

	task automatic set_config(input int ts, sc, sh, tw, th, mc);
		write_reg(CFG_TILE_SIZE, ts);
		write_reg(CFG_WALL_SCALE, sc);
		write_reg(CFG_SCREEN_H, sh);
		write_reg(CFG_TEX_W, tw);
		write_reg(CFG_TEX_H, th);
		write_reg(CFG_MAP_COLUMNS, mc);
	endtask

	initial begin
		in_word_t w;
		int k;
		cmd.valid <= 1'b0;
		cmd.data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		// texture area in use is loaded so no read of an unwritten texel;
		// texture width and height stay at 8 or below from here on
		load_all_texels();
		set_config(64, 64, 600, 8, 8, 24);
		// pixel before any column
		w = rand_word(KIND_PIXEL); w.screen_row = 0; send_word(w);
		w = rand_word(KIND_PIXEL); w.screen_row = 10'h3FF; send_word(w);
		w = rand_word(KIND_COLUMN); w.ray_distance = 0; w.hit_fraction = 0;
		w.hit_axis = 0; w.step_x_positive = 1; send_word(w);
		w = rand_word(KIND_PIXEL); w.screen_row = 300; send_word(w);
		w = rand_word(KIND_COLUMN); w.ray_distance = 24'hFFFFFF;
		w.hit_fraction = 16'hFFFF; w.hit_axis = 1; w.step_y_negative = 1; send_word(w);
		w = rand_word(KIND_PIXEL); w.screen_row = 300; send_word(w);
		w = rand_word(KIND_PIXEL); w.screen_row = 0; send_word(w);
		w = rand_word(KIND_COLUMN); w.ray_distance = 24'd256; w.hit_axis = 1;
		w.step_y_negative = 0; send_word(w);
		for (int r = 0; r < 3; r++) begin
			w = rand_word(KIND_PIXEL); w.screen_row = 10'(r * 299); send_word(w);
		end
		w = rand_word(2'd3); send_word(w);
		wait_drained();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_config(1, 1, 2, 1, 1, 1);
				1: set_config(255, 1023, 1024, 8, 8, 255);
				2: set_config(0, 1023, 2047, 0, 0, 0);
				3: set_config(16, 200, 480, 5, 7, 10);
				4: set_config($urandom_range(1, 255), $urandom_range(1, 1023),
					$urandom_range(2, 1024), $urandom_range(1, 8),
					$urandom_range(1, 8), $urandom_range(1, 255));
				default: set_config(64, 64, 600, 8, 8, 24);
			endcase
			for (int n = 0; n < 120; n++) begin
				k = $urandom_range(0, 19);
				if (k < 3) w = rand_word(KIND_COLUMN);
				else if (k < 18) w = rand_word(KIND_PIXEL);
				else if (k < 19) w = rand_word(KIND_LOAD);
				else w = rand_word(2'd3);
				send_word(w);
				if (n == 60) wait_drained();
			end
			wait_drained();
		end
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#30ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/twcs_pkg.sv
hdl/twcs_stream_if.sv
hdl/twcs_ram.sv
hdl/twcs_div.sv
hdl/textured_wall_column_shader.sv
dv/twcs_checker.sv
dv/tb.sv
